// ===== src/fbes_pkg.sv =====
// Shared types, constants and helpers of the free bitmap extent summary unit.
`default_nettype none

package fbes_pkg;

  // Table size and counter width
  localparam int MAX_ENTRIES = 8;
  localparam int COUNT_BITS  = 24;

  // Derived widths
  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int BLK_W     = 32;
  localparam int MINLEN_W  = 24;
  localparam int OUT_CNT_W = 4;
  localparam int CFG_W     = 32;

  // Item operation codes
  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_EXTENT = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_CHECK  = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FIRST_DATA_BLOCK    = 2'd0,
    CFG_MIN_RUN_LENGTH      = 2'd1,
    CFG_CONTINUE_AFTER_FULL = 2'd2,
    CFG_SCAN_INHIBIT        = 2'd3
  } cfg_idx_e;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DONE  = 3'b010,
    ST_CHECK = 3'b100
  } state_e;

  // One summary table entry
  typedef struct packed {
    logic [BLK_W-1:0]      start;
    logic [COUNT_BITS-1:0] len;
  } entry_t;

  // Outcome of the scan item being accepted this cycle
  typedef struct packed {
    logic                  rec;
    logic [BLK_W-1:0]      start;
    logic [COUNT_BITS-1:0] len;
    logic [CNT_W-1:0]      used;
    logic [COUNT_BITS-1:0] stored_free;
    logic                  free_valid;
  } scan_upd_t;

  // Saturating counter increment
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage

`default_nettype wire

// ===== src/fbes_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module fbes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/fbes_scan.sv =====
// Scan counters, run detection and table fill control.
`default_nettype none

module fbes_scan (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                scan_go_i,
  input  wire logic                                map_bit_i,
  input  wire logic                                last_bit_i,
  input  wire logic [fbes_pkg::BLK_W-1:0]          first_data_block_i,
  input  wire logic [fbes_pkg::MINLEN_W-1:0]       min_run_length_i,
  input  wire logic                                continue_after_full_i,
  input  wire logic                                invalidate_i,
  output fbes_pkg::scan_upd_t                      upd_o,
  output logic                                     wr_en_o,
  output logic      [fbes_pkg::IDX_W-1:0]          wr_addr_o,
  output logic      [fbes_pkg::CNT_W-1:0]          used_o,
  output logic      [fbes_pkg::CNT_W-1:0]          live_o,
  output logic      [fbes_pkg::COUNT_BITS-1:0]     stored_o
);

  import fbes_pkg::*;

  logic [CNT_W-1:0]      used_q, used_d, used_b;
  logic [CNT_W-1:0]      live_q, live_d, live_b;
  logic [COUNT_BITS-1:0] pos_q, pos_d, pos_b;
  logic [COUNT_BITS-1:0] run_q, run_d, run_b, run_inc;
  logic [COUNT_BITS-1:0] free_q, free_d, free_b;
  logic [COUNT_BITS-1:0] stored_q, stored_d;
  logic                  stop_q, stop_d, stop_b;
  logic                  active_q, active_d;
  logic [MINLEN_W-1:0]   minlen;
  logic [COUNT_BITS:0]   endpos;
  logic                  rec;
  logic                  free_valid;

  // Scan update for the bit being accepted
  always_comb begin
    // a new scan starts from cleared counters
    used_b = active_q ? used_q : '0;
    live_b = active_q ? live_q : '0;
    pos_b  = active_q ? pos_q  : '0;
    run_b  = active_q ? run_q  : '0;
    free_b = active_q ? free_q : '0;
    stop_b = active_q ? stop_q : 1'b0;

    minlen  = (min_run_length_i == '0) ? MINLEN_W'(1) : min_run_length_i;
    endpos  = {1'b0, pos_b} + (COUNT_BITS + 1)'(map_bit_i);
    run_inc = map_bit_i ? sat_inc(run_b) : run_b;

    used_d = used_b;
    pos_d  = pos_b;
    run_d  = run_b;
    free_d = free_b;
    stop_d = stop_b;
    rec    = 1'b0;

    if (!stop_b) begin
      run_d = run_inc;
      if (map_bit_i) begin
        free_d = sat_inc(free_b);
      end
      // run ends at a clear bit or at the end of the group
      if ((!map_bit_i || last_bit_i) && (run_inc != '0)) begin
        if ((32'(run_inc) >= 32'(minlen)) && (used_b < CNT_W'(MAX_ENTRIES))) begin
          rec    = 1'b1;
          used_d = used_b + CNT_W'(1);
          if (!continue_after_full_i && (used_d == CNT_W'(MAX_ENTRIES))) begin
            stop_d = 1'b1;
          end
        end
        run_d = '0;
      end
      pos_d = sat_inc(pos_b);
    end

    free_valid = last_bit_i && !stop_d && continue_after_full_i;
    stored_d   = free_valid ? free_d : stored_q;
    active_d   = !last_bit_i;

    // a found overlap kills every live entry
    live_d = scan_go_i ? live_b : live_q;
    if (invalidate_i) begin
      live_d = CNT_W'(MAX_ENTRIES);
    end
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      live_q   <= '0;
      pos_q    <= '0;
      run_q    <= '0;
      free_q   <= '0;
      stored_q <= '0;
      stop_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      live_q <= live_d;
      if (scan_go_i) begin
        used_q   <= used_d;
        pos_q    <= pos_d;
        run_q    <= run_d;
        free_q   <= free_d;
        stored_q <= stored_d;
        stop_q   <= stop_d;
        active_q <= active_d;
      end
    end
  end

  assign upd_o.rec         = rec;
  assign upd_o.start       = BLK_W'({1'b0, first_data_block_i} + 33'(endpos) - 33'(run_inc));
  assign upd_o.len         = run_inc;
  assign upd_o.used        = used_d;
  assign upd_o.stored_free = stored_d;
  assign upd_o.free_valid  = free_valid;

  assign wr_en_o   = scan_go_i && rec;
  assign wr_addr_o = used_b[IDX_W-1:0];
  assign used_o    = used_q;
  assign live_o    = live_q;
  assign stored_o  = stored_q;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_stop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> (used_q == CNT_W'(MAX_ENTRIES)))
    else $error("scan stopped with table not full");
`endif

endmodule

`default_nettype wire

// ===== src/fbes_check.sv =====
// Overlap check walker: steps through live table entries and compares extents.
`default_nettype none

module fbes_check (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             load_i,
  input  wire logic                             step_i,
  input  wire logic [fbes_pkg::BLK_W-1:0]       alloc_start_i,
  input  wire logic [fbes_pkg::COUNT_BITS-1:0]  alloc_length_i,
  input  wire logic [fbes_pkg::CNT_W-1:0]       live_i,
  input  wire logic [fbes_pkg::CNT_W-1:0]       used_i,
  input  wire fbes_pkg::entry_t                 rd_data_i,
  output logic      [fbes_pkg::IDX_W-1:0]       rd_addr_o,
  output logic                                  any_o,
  output logic                                  more_o,
  output logic                                  hit_o
);

  import fbes_pkg::*;

  logic [CNT_W-1:0]      ptr_q, ptr_d, nxt;
  logic [BLK_W-1:0]      a_start_q;
  logic [COUNT_BITS-1:0] a_len_q;
  logic [BLK_W:0]        e_end, a_end;

  // Entry pointer: next read follows the one in flight
  assign nxt       = ptr_q + CNT_W'(1);
  assign rd_addr_o = load_i ? live_i[IDX_W-1:0] : nxt[IDX_W-1:0];
  assign any_o     = live_i < used_i;
  assign more_o    = nxt < used_i;

  always_comb begin
    ptr_d = ptr_q;
    if (load_i) begin
      ptr_d = live_i;
    end else if (step_i) begin
      ptr_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // Extent under test
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_start_q <= alloc_start_i;
      a_len_q   <= alloc_length_i;
    end
  end

  // Overlap compare against the entry read last cycle
  assign e_end = {1'b0, rd_data_i.start} + (BLK_W + 1)'(rd_data_i.len);
  assign a_end = {1'b0, a_start_q} + (BLK_W + 1)'(a_len_q);
  assign hit_o = ((rd_data_i.start <= a_start_q) && (e_end > {1'b0, a_start_q})) ||
                 ((a_start_q <= rd_data_i.start) && (a_end > {1'b0, rd_data_i.start}));

endmodule

`default_nettype wire

// ===== src/free_bitmap_extent_summary_unit.sv =====
// Top level of the free bitmap extent summary unit.
// A scan item (one bitmap bit) is taken every cycle while busy is low; its
// results show up the cycle after acceptance. A bit that closes a recorded
// run and is also the last bit of the group yields an extent record and then
// a scan done record, so it holds busy until the scan done record is out. A
// check item with no live table entry reports no overlap without a walk; otherwise
// live entries are compared one at a time, as they come through the read port of the
// summary table RAM; the walk stops at the first overlap. Each result is on
// the result ports for a single cycle, marked by result_valid_o, and must be
// taken then. Configuration writes are always ready and belong to idle times.
`default_nettype none

module free_bitmap_extent_summary_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // item command
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             operation_i,
  input  wire logic                             map_bit_i,
  input  wire logic                             last_bit_i,
  input  wire logic [fbes_pkg::BLK_W-1:0]       alloc_start_i,
  input  wire logic [fbes_pkg::COUNT_BITS-1:0]  alloc_length_i,
  // results
  output logic                                  result_valid_o,
  output logic      [1:0]                       kind_o,
  output logic      [fbes_pkg::BLK_W-1:0]       extent_start_o,
  output logic      [fbes_pkg::COUNT_BITS-1:0]  extent_length_o,
  output logic      [fbes_pkg::OUT_CNT_W-1:0]   entry_count_o,
  output logic      [fbes_pkg::COUNT_BITS-1:0]  free_total_o,
  output logic                                  free_total_valid_o,
  output logic                                  overlap_found_o,
  output logic                                  last_o,
  // configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire fbes_pkg::cfg_idx_e               cfg_index_i,
  input  wire logic [fbes_pkg::CFG_W-1:0]       cfg_data_i
);

  import fbes_pkg::*;

  state_e                state_q, state_d;
  logic [BLK_W-1:0]      first_block_q;
  logic [MINLEN_W-1:0]   min_run_q;
  logic                  caf_q;
  logic                  inhibit_q;

  logic                  accept, scan_go, check_go;
  scan_upd_t             upd;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  entry_t                wr_entry, rd_entry;
  logic [CNT_W-1:0]      used, live;
  logic [COUNT_BITS-1:0] stored;
  logic                  chk_any, chk_more, chk_hit;
  logic                  invalidate, step;

  logic                  pend_fval_q, pend_fval_d;
  logic                  out_v_q, out_v_d;
  kind_e                 kind_q, kind_d;
  logic [BLK_W-1:0]      estart_q, estart_d;
  logic [COUNT_BITS-1:0] elen_q, elen_d;
  logic [OUT_CNT_W-1:0]  cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] ftot_q, ftot_d;
  logic                  fval_q, fval_d;
  logic                  ovl_q, ovl_d;
  logic                  last_q, last_d;

  // Handshake
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign scan_go     = accept && (operation_i == OP_SCAN) && !inhibit_q;
  assign check_go    = accept && (operation_i == OP_CHECK);
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_block_q <= '0;
      min_run_q     <= MINLEN_W'(1);
      caf_q         <= 1'b0;
      inhibit_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FIRST_DATA_BLOCK:    first_block_q <= cfg_data_i[BLK_W-1:0];
        CFG_MIN_RUN_LENGTH:      min_run_q     <= cfg_data_i[MINLEN_W-1:0];
        CFG_CONTINUE_AFTER_FULL: caf_q         <= cfg_data_i[0];
        CFG_SCAN_INHIBIT:        inhibit_q     <= cfg_data_i[0];
        default:                 ;
      endcase
    end
  end

  fbes_scan u_scan (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .scan_go_i             (scan_go),
    .map_bit_i             (map_bit_i),
    .last_bit_i            (last_bit_i),
    .first_data_block_i    (first_block_q),
    .min_run_length_i      (min_run_q),
    .continue_after_full_i (caf_q),
    .invalidate_i          (invalidate),
    .upd_o                 (upd),
    .wr_en_o               (wr_en),
    .wr_addr_o             (wr_addr),
    .used_o                (used),
    .live_o                (live),
    .stored_o              (stored)
  );

  assign wr_entry.start = upd.start;
  assign wr_entry.len   = upd.len;

  // Summary table
  fbes_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  fbes_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (check_go),
    .step_i         (step),
    .alloc_start_i  (alloc_start_i),
    .alloc_length_i (alloc_length_i),
    .live_i         (live),
    .used_i         (used),
    .rd_data_i      (rd_entry),
    .rd_addr_o      (rd_addr),
    .any_o          (chk_any),
    .more_o         (chk_more),
    .hit_o          (chk_hit)
  );

  // Sequencer and result selection
  always_comb begin
    state_d     = state_q;
    pend_fval_d = pend_fval_q;
    out_v_d     = 1'b0;
    kind_d      = KIND_EXTENT;
    estart_d    = '0;
    elen_d      = '0;
    cnt_d       = OUT_CNT_W'(used);
    ftot_d      = stored;
    fval_d      = 1'b0;
    ovl_d       = 1'b0;
    last_d      = 1'b1;
    invalidate  = 1'b0;
    step        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (scan_go) begin
          cnt_d = OUT_CNT_W'(upd.used);
          if (upd.rec) begin
            out_v_d  = 1'b1;
            kind_d   = KIND_EXTENT;
            estart_d = upd.start;
            elen_d   = upd.len;
            ftot_d   = '0;
            last_d   = !last_bit_i;
            if (last_bit_i) begin
              // scan done follows the record
              state_d     = ST_DONE;
              pend_fval_d = upd.free_valid;
            end
          end else if (last_bit_i) begin
            out_v_d = 1'b1;
            kind_d  = KIND_DONE;
            ftot_d  = upd.stored_free;
            fval_d  = upd.free_valid;
          end
        end else if (check_go) begin
          if (chk_any) begin
            state_d = ST_CHECK;
          end else begin
            out_v_d = 1'b1;
            kind_d  = KIND_CHECK;
          end
        end
      end
      ST_DONE: begin
        out_v_d = 1'b1;
        kind_d  = KIND_DONE;
        fval_d  = pend_fval_q;
        state_d = ST_IDLE;
      end
      ST_CHECK: begin
        if (chk_hit) begin
          invalidate = 1'b1;
          out_v_d    = 1'b1;
          kind_d     = KIND_CHECK;
          ovl_d      = 1'b1;
          state_d    = ST_IDLE;
        end else if (chk_more) begin
          step = 1'b1;
        end else begin
          out_v_d = 1'b1;
          kind_d  = KIND_CHECK;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_v_q     <= 1'b0;
      pend_fval_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_v_q     <= out_v_d;
      pend_fval_q <= pend_fval_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    estart_q <= estart_d;
    elen_q   <= elen_d;
    cnt_q    <= cnt_d;
    ftot_q   <= ftot_d;
    fval_q   <= fval_d;
    ovl_q    <= ovl_d;
    last_q   <= last_d;
  end

  assign result_valid_o     = out_v_q;
  assign kind_o             = kind_q;
  assign extent_start_o     = estart_q;
  assign extent_length_o    = elen_q;
  assign entry_count_o      = cnt_q;
  assign free_total_o       = ftot_q;
  assign free_total_valid_o = fval_q;
  assign overlap_found_o    = ovl_q;
  assign last_o             = last_q;

`ifndef NO_ASSERTIONS
  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (result_valid_o && (kind_o == KIND_DONE) && last_o))
    else $error("pending scan done not emitted");

  a_record_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o == KIND_EXTENT) && !last_o) |=>
      (result_valid_o && (kind_o == KIND_DONE)))
    else $error("extent record without following scan done");

  a_overlap_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && overlap_found_o) |-> $past(state_q == ST_CHECK))
    else $error("overlap reported outside entry walk");
`endif

endmodule

`default_nettype wire
